// ----- src/fsvs_pkg.sv -----
// Shared types, widths, constants and helper functions of the fair-share scheduler.
package fsvs_pkg;

    localparam int VR_W          = 48;
    localparam int TASK_W        = 4;
    localparam int NICE_W        = 3;
    localparam int ELAPSED_W     = 24;
    localparam int WEIGHT_W      = 9;
    localparam int PROD_W        = ELAPSED_W + WEIGHT_W;
    localparam int COUNT_W       = 5;
    localparam int ID_W          = 5;
    localparam int SLICE_W       = 16;
    localparam int CMD_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_W       = VR_W + NICE_W + TASK_W;
    localparam int MAX_TASKS_DEF = 16;
    localparam int NICE_LEVELS   = 5;

    localparam logic [SLICE_W-1:0] SLICE_LIMIT_RST = 16'd10;

    // 1.25^nice in Q8, nice -2..2
    localparam logic [WEIGHT_W-1:0] NICE_WEIGHT [NICE_LEVELS] =
        '{9'd164, 9'd205, 9'd256, 9'd320, 9'd400};

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_START = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_DONE  = 2'd3
    } status_t;

    typedef struct packed {
        logic    latch_in;
        logic    add_load;
        logic    mul_en;
        logic    vr_en;
        logic    rd_en;
        logic    rd_head;
        logic    scan_dec;
        logic    wr_shift;
        logic    wr_ins;
        logic    take_head;
        logic    scan_from_take;
        logic    set_started;
        logic    tick_update;
        logic    run_vr_load;
        logic    out_load;
        status_t out_status;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic finished;
        logic started;
        logic full;
        logic empty;
        logic scan_zero;
        logic scan_one;
        logic head_gt;
    } dp_sts_t;

    function automatic logic signed [NICE_W-1:0] nice_clamp(input logic signed [NICE_W-1:0] n);
        logic signed [NICE_W-1:0] r;
        r = n;
        if (n < -3'sd2)
        begin
            r = -3'sd2;
        end
        else if (n > 3'sd2)
        begin
            r = 3'sd2;
        end
        return r;
    endfunction

    function automatic logic [WEIGHT_W-1:0] nice_weight(input logic signed [NICE_W-1:0] n);
        logic [NICE_W-1:0] idx;
        idx = NICE_W'(n + 3'sd2);
        if (idx < NICE_W'(NICE_LEVELS))
        begin
            return NICE_WEIGHT[idx];
        end
        return NICE_WEIGHT[NICE_LEVELS-1];
    endfunction

endpackage

// ----- src/fsvs_if.sv -----
// Handshake channel interfaces: scheduler commands in, scheduler results out.
interface fsvs_req_if import fsvs_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [CMD_W-1:0]            command;
    logic signed [NICE_W-1:0]    nice_level;
    logic [ELAPSED_W-1:0]        elapsed;

    modport source (output valid, command, nice_level, elapsed, input ready);
    modport sink   (input valid, command, nice_level, elapsed, output ready);
endinterface

interface fsvs_rsp_if import fsvs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [TASK_W-1:0]     running_task;
    logic [VR_W-1:0]       running_vruntime;
    logic [COUNT_W-1:0]    queued_count;
    logic                  finished;
    logic [STATUS_W-1:0]   status;

    modport source (output valid, running_task, running_vruntime, queued_count, finished,
                    status, input ready);
    modport sink   (input valid, running_task, running_vruntime, queued_count, finished,
                    status, output ready);
endinterface

// ----- src/fsvs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fsvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/fsvs_ctrl.sv -----
// Scheduler controller: command decode and run-queue walk sequencing.
module fsvs_ctrl import fsvs_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    output logic    rsp_valid,
    input  logic    rsp_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_DECODE  = 9'b000000010,
        S_START   = 9'b000000100,
        S_ADD     = 9'b000001000,
        S_TCMP    = 9'b000010000,
        S_INS_RD  = 9'b000100000,
        S_INS_CMP = 9'b001000000,
        S_RESP    = 9'b010000000,
        S_SPARE   = 9'b100000000
    } state_t;

    state_t  state_reg, state_next;
    status_t stat_reg, stat_next;
    logic    rsp_valid_reg, rsp_valid_next;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        stat_next  = stat_reg;
        cmd        = '0;
        cmd.out_status = stat_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.latch_in = 1'b1;
                    stat_next    = ST_OK;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_RESP;
                if (sts.finished)
                begin
                    stat_next = ST_DONE;
                end
                else
                begin
                    unique case (sts.cmd)
                        CMD_ADD:
                        begin
                            if (sts.full)
                            begin
                                stat_next = ST_FULL;
                            end
                            else
                            begin
                                cmd.add_load = 1'b1;
                                state_next   = S_INS_RD;
                            end
                        end
                        CMD_START:
                        begin
                            if (!sts.started)
                            begin
                                if (sts.empty)
                                begin
                                    stat_next = ST_EMPTY;
                                end
                                else
                                begin
                                    cmd.rd_en   = 1'b1;
                                    cmd.rd_head = 1'b1;
                                    state_next  = S_START;
                                end
                            end
                        end
                        CMD_TICK:
                        begin
                            if (!sts.started)
                            begin
                                stat_next = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.mul_en = 1'b1;
                                state_next = S_ADD;
                            end
                        end
                        CMD_NOP:
                        begin
                            stat_next = ST_OK;
                        end
                    endcase
                end
            end
            S_START:
            begin
                cmd.take_head   = 1'b1;
                cmd.set_started = 1'b1;
                state_next      = S_RESP;
            end
            S_ADD:
            begin
                cmd.vr_en   = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_head = 1'b1;
                state_next  = S_TCMP;
            end
            S_TCMP:
            begin
                cmd.tick_update = 1'b1;
                if (sts.empty || sts.head_gt)
                begin
                    cmd.run_vr_load = 1'b1;
                    state_next      = S_RESP;
                end
                else
                begin
                    cmd.take_head      = 1'b1;
                    cmd.scan_from_take = 1'b1;
                    state_next         = S_INS_RD;
                end
            end
            S_INS_RD:
            begin
                if (sts.scan_zero)
                begin
                    cmd.wr_ins = 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (sts.head_gt)
                begin
                    cmd.wr_shift = 1'b1;
                    cmd.scan_dec = 1'b1;
                    if (sts.scan_one)
                    begin
                        state_next = S_INS_RD;
                    end
                    else
                    begin
                        cmd.rd_en = 1'b1;
                    end
                end
                else
                begin
                    cmd.wr_ins = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SPARE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            stat_reg      <= ST_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stat_reg      <= stat_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ----- src/fsvs_dp.sv -----
// Scheduler datapath: run-queue RAM as a ring, running task, weight multiply, result register.
module fsvs_dp import fsvs_pkg::*; #(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [SLICE_W-1:0]       cfg_wdata,
    input  logic [CMD_W-1:0]         req_command,
    input  logic signed [NICE_W-1:0] req_nice_level,
    input  logic [ELAPSED_W-1:0]     req_elapsed,
    input  dp_cmd_t                  cmd,
    output dp_sts_t                  sts,
    output logic [TASK_W-1:0]        running_task,
    output logic [VR_W-1:0]          running_vruntime,
    output logic [COUNT_W-1:0]       queued_count,
    output logic                     finished,
    output logic [STATUS_W-1:0]      status
);

    localparam int AW = $clog2(MAX_TASKS);
    localparam int LW = $clog2(MAX_TASKS + 1);

    // input transaction
    cmd_t                     cmd_in_reg;
    logic signed [NICE_W-1:0] nice_in_reg;
    logic [ELAPSED_W-1:0]     elapsed_reg;

    // queue bookkeeping
    logic [AW-1:0] hd_reg;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] scan_reg;
    logic [ID_W-1:0] next_id_reg;

    // entry being inserted
    logic [VR_W-1:0]          ins_vr_reg;
    logic signed [NICE_W-1:0] ins_nice_reg;
    logic [TASK_W-1:0]        ins_task_reg;

    // running task
    logic [VR_W-1:0]          run_vr_reg;
    logic signed [NICE_W-1:0] run_nice_reg;
    logic [TASK_W-1:0]        run_task_reg;

    logic [PROD_W-1:0]  prod_reg;
    logic [SLICE_W-1:0] slice_reg;
    logic [SLICE_W-1:0] limit_reg;
    logic               started_reg;
    logic               finished_reg;

    // result register
    logic [TASK_W-1:0]   out_task_reg;
    logic [VR_W-1:0]     out_vr_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic                out_finished_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [VR_W-1:0]    rd_vr;
    logic signed [NICE_W-1:0] rd_nice;
    logic [TASK_W-1:0]  rd_task;
    logic [LW-1:0]      scan_after;
    logic [VR_W:0]      vr_sum;
    logic [VR_W-1:0]    vr_sat;
    logic [SLICE_W-1:0] slice_inc;

    // logical queue position to RAM address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [LW-1:0] k);
        logic [LW:0] s;
        s = (LW+1)'(hd) + (LW+1)'(k);
        if (s >= (LW+1)'(MAX_TASKS))
        begin
            s = s - (LW+1)'(MAX_TASKS);
        end
        return s[AW-1:0];
    endfunction

    assign rd_vr   = ram_rdata[ENTRY_W-1 -: VR_W];
    assign rd_nice = ram_rdata[TASK_W +: NICE_W];
    assign rd_task = ram_rdata[TASK_W-1:0];

    assign scan_after = cmd.scan_dec ? scan_reg - LW'(1) : scan_reg;
    assign ram_raddr  = cmd.rd_head ? hd_reg : phys(hd_reg, scan_after - LW'(1));
    assign ram_waddr  = phys(hd_reg, scan_reg);
    assign ram_wdata  = cmd.wr_ins ? {ins_vr_reg, ins_nice_reg, ins_task_reg} : ram_rdata;

    assign vr_sum    = {1'b0, run_vr_reg} + (VR_W+1)'(prod_reg);
    assign vr_sat    = vr_sum[VR_W] ? '1 : vr_sum[VR_W-1:0];
    assign slice_inc = slice_reg + SLICE_W'(1);

    fsvs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_queue (
        .clk   (clk),
        .we    (cmd.wr_ins | cmd.wr_shift),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        sts.cmd       = cmd_in_reg;
        sts.finished  = finished_reg;
        sts.started   = started_reg;
        sts.full      = (len_reg >= LW'(MAX_TASKS));
        sts.empty     = (len_reg == '0);
        sts.scan_zero = (scan_reg == '0);
        sts.scan_one  = (scan_reg == LW'(1));
        sts.head_gt   = (rd_vr > ins_vr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hd_reg       <= '0;
            len_reg      <= '0;
            scan_reg     <= '0;
            next_id_reg  <= '0;
            run_vr_reg   <= '0;
            run_nice_reg <= '0;
            run_task_reg <= '0;
            slice_reg    <= '0;
            limit_reg    <= SLICE_LIMIT_RST;
            started_reg  <= 1'b0;
            finished_reg <= 1'b0;
            cmd_in_reg   <= CMD_NOP;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (cmd.latch_in)
            begin
                cmd_in_reg <= cmd_t'(req_command);
            end
            if (cmd.add_load)
            begin
                scan_reg    <= len_reg;
                next_id_reg <= next_id_reg + ID_W'(1);
            end
            else if (cmd.scan_from_take)
            begin
                scan_reg <= len_reg - LW'(1);
            end
            else if (cmd.scan_dec)
            begin
                scan_reg <= scan_reg - LW'(1);
            end
            if (cmd.take_head)
            begin
                hd_reg       <= phys(hd_reg, LW'(1));
                len_reg      <= len_reg - LW'(1);
                run_vr_reg   <= rd_vr;
                run_nice_reg <= rd_nice;
                run_task_reg <= rd_task;
            end
            else if (cmd.wr_ins)
            begin
                len_reg <= len_reg + LW'(1);
            end
            if (cmd.run_vr_load)
            begin
                run_vr_reg <= ins_vr_reg;
            end
            if (cmd.set_started)
            begin
                started_reg <= 1'b1;
            end
            if (cmd.tick_update)
            begin
                slice_reg <= slice_inc;
                if (slice_inc >= limit_reg)
                begin
                    finished_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            nice_in_reg <= req_nice_level;
            elapsed_reg <= req_elapsed;
        end
        if (cmd.add_load)
        begin
            ins_vr_reg   <= '0;
            ins_nice_reg <= nice_clamp(nice_in_reg);
            ins_task_reg <= next_id_reg[TASK_W-1:0];
        end
        else if (cmd.vr_en)
        begin
            ins_vr_reg   <= vr_sat;
            ins_nice_reg <= run_nice_reg;
            ins_task_reg <= run_task_reg;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= elapsed_reg * nice_weight(run_nice_reg);
        end
        if (cmd.out_load)
        begin
            out_task_reg     <= run_task_reg;
            out_vr_reg       <= run_vr_reg;
            out_count_reg    <= COUNT_W'(len_reg);
            out_finished_reg <= finished_reg;
            out_status_reg   <= cmd.out_status;
        end
    end

    assign running_task     = out_task_reg;
    assign running_vruntime = out_vr_reg;
    assign queued_count     = out_count_reg;
    assign finished         = out_finished_reg;
    assign status           = out_status_reg;

endmodule

// ----- src/fair_share_vruntime_scheduler_unit.sv -----
// Fair-share vruntime scheduler top level: controller, datapath and channels.
// Ignored or rejected commands go straight to the result register; an add, or a tick that
// sends the running task back, walks the queue from its tail and shifts back each entry with
// a larger vruntime. One transaction at a time, taken the cycle after the result loads;
// a result not yet taken holds the unit. rst_n clears control and running state, not the RAM.
module fair_share_vruntime_scheduler_unit import fsvs_pkg::*; #(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [SLICE_W-1:0] cfg_wdata,
    fsvs_req_if.sink           req,
    fsvs_rsp_if.source         rsp
);

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    fsvs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (dp_sts),
        .cmd       (dp_cmd)
    );

    fsvs_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .req_command      (req.command),
        .req_nice_level   (req.nice_level),
        .req_elapsed      (req.elapsed),
        .cmd              (dp_cmd),
        .sts              (dp_sts),
        .running_task     (rsp.running_task),
        .running_vruntime (rsp.running_vruntime),
        .queued_count     (rsp.queued_count),
        .finished         (rsp.finished),
        .status           (rsp.status)
    );

endmodule

// ----- test/tb_fair_share_vruntime_scheduler_unit.sv -----
// Testbench for the fair-share vruntime scheduler: random and directed traffic vs. a predictor.
`timescale 1ns / 100ps

module tb_fair_share_vruntime_scheduler_unit;
    import fsvs_pkg::*;

    localparam logic [63:0] VR_CEIL     = 64'h0000_FFFF_FFFF_FFFF;
    localparam int          STALL_LIMIT = 2000;
    localparam int          MAX_REPORTS = 40;

    typedef enum int {
        FLOW_FREE,
        FLOW_SEND_GAPS,
        FLOW_RECV_STALLS,
        FLOW_BOTH
    } flow_t;

    typedef struct {
        cmd_t                     cmd;
        logic signed [NICE_W-1:0] nice;
        logic [ELAPSED_W-1:0]     elapsed;
    } sched_cmd_t;

    typedef struct {
        logic [TASK_W-1:0]  task_id;
        logic [VR_W-1:0]    vruntime;
        logic [COUNT_W-1:0] waiting;
        logic               done;
        status_t            status;
    } sched_result_t;

    typedef struct {
        logic [63:0]              vr;
        logic signed [NICE_W-1:0] nice;
        logic [TASK_W-1:0]        id;
    } rq_entry_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [SLICE_W-1:0] cfg_wdata;

    fsvs_req_if cmd_ch ();
    fsvs_rsp_if res_ch ();

    fair_share_vruntime_scheduler_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (cmd_ch),
        .rsp       (res_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predicted scheduler state
    rq_entry_t                run_queue [$];
    logic [63:0]              run_vr        = '0;
    logic signed [NICE_W-1:0] run_nice      = '0;
    logic [TASK_W-1:0]        run_task      = '0;
    logic [SLICE_W-1:0]       slices        = '0;
    logic [SLICE_W-1:0]       slice_lim     = SLICE_LIMIT_RST;
    logic [ID_W-1:0]          next_id       = '0;
    logic                     sched_started = 1'b0;
    logic                     sched_done    = 1'b0;

    sched_cmd_t    backlog [$];
    sched_cmd_t    in_item;
    sched_result_t results_due [$];
    sched_result_t due_now;
    flow_t         flow         = FLOW_FREE;
    int            sent_total   = 0;
    int            result_total = 0;
    int            mismatches   = 0;

    function automatic void insert_by_vruntime(rq_entry_t e);
        int pos;
        pos = 0;
        while (pos < run_queue.size() && run_queue[pos].vr <= e.vr)
        begin
            pos++;
        end
        run_queue.insert(pos, e);
    endfunction

    function automatic void dispatch_head();
        rq_entry_t h;
        h        = run_queue.pop_front();
        run_vr   = h.vr;
        run_nice = h.nice;
        run_task = h.id;
    endfunction

    function automatic sched_result_t advance_scheduler(sched_cmd_t it);
        sched_result_t            r;
        rq_entry_t                moved;
        logic signed [NICE_W-1:0] nc;
        logic [63:0]              charge;
        logic [63:0]              nvr;
        r.status = ST_OK;
        if (sched_done)
        begin
            r.status = ST_DONE;
        end
        else
        begin
            case (it.cmd)
                CMD_ADD:
                begin
                    nc = it.nice;
                    if (nc < -3'sd2)
                    begin
                        nc = -3'sd2;
                    end
                    else if (nc > 3'sd2)
                    begin
                        nc = 3'sd2;
                    end
                    if (run_queue.size() >= MAX_TASKS_DEF)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        insert_by_vruntime('{vr: 64'd0, nice: nc, id: next_id[TASK_W-1:0]});
                        next_id = next_id + 1'b1;
                    end
                end
                CMD_START:
                begin
                    if (!sched_started)
                    begin
                        if (run_queue.size() == 0)
                        begin
                            r.status = ST_EMPTY;
                        end
                        else
                        begin
                            dispatch_head();
                            sched_started = 1'b1;
                        end
                    end
                end
                CMD_TICK:
                begin
                    if (!sched_started)
                    begin
                        r.status = ST_EMPTY;
                    end
                    else
                    begin
                        charge = 64'(it.elapsed) * 64'(NICE_WEIGHT[int'(run_nice) + 2]);
                        nvr = (charge > VR_CEIL - run_vr) ? VR_CEIL : run_vr + charge;
                        if (run_queue.size() == 0 || run_queue[0].vr > nvr)
                        begin
                            run_vr = nvr;
                        end
                        else
                        begin
                            moved = '{vr: nvr, nice: run_nice, id: run_task};
                            dispatch_head();
                            insert_by_vruntime(moved);
                        end
                        slices = slices + 1'b1;
                        if (slices >= slice_lim)
                        begin
                            sched_done = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        r.task_id  = run_task;
        r.vruntime = run_vr[VR_W-1:0];
        r.waiting  = COUNT_W'(run_queue.size());
        r.done     = sched_done;
        return r;
    endfunction

    function automatic sched_cmd_t random_cmd();
        sched_cmd_t it;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            it.cmd = CMD_ADD;
        end
        else if (pick < 22)
        begin
            it.cmd = CMD_START;
        end
        else if (pick < 92)
        begin
            it.cmd = CMD_TICK;
        end
        else
        begin
            it.cmd = CMD_NOP;
        end
        it.nice = NICE_W'($urandom_range(7));
        pick = $urandom_range(99);
        if (pick < 20)
        begin
            it.elapsed = '0;
        end
        else if (pick < 60)
        begin
            it.elapsed = ELAPSED_W'($urandom_range(255));
        end
        else if (pick < 85)
        begin
            it.elapsed = ELAPSED_W'($urandom_range(65535));
        end
        else
        begin
            it.elapsed = ELAPSED_W'($urandom);
        end
        return it;
    endfunction

    task automatic queue_cmd(input cmd_t c, input logic [NICE_W-1:0] n,
                             input logic [ELAPSED_W-1:0] e);
        backlog.push_back('{cmd: c, nice: n, elapsed: e});
        sent_total++;
    endtask

    task automatic queue_random(input int count);
        repeat (count)
        begin
            backlog.push_back(random_cmd());
            sent_total++;
        end
    endtask

    task automatic set_slice_limit(input logic [SLICE_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        slice_lim = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (result_total != sent_total)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            if (mismatches < MAX_REPORTS)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
            end
            mismatches++;
        end
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                results_due.push_back(advance_scheduler(in_item));
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (backlog.size() != 0 &&
                    !((flow == FLOW_SEND_GAPS && $urandom_range(99) < 74) ||
                      (flow == FLOW_BOTH && $urandom_range(99) < 6)))
                begin
                    in_item = backlog.pop_front();
                    cmd_ch.valid      <= 1'b1;
                    cmd_ch.command    <= in_item.cmd;
                    cmd_ch.nice_level <= in_item.nice;
                    cmd_ch.elapsed    <= in_item.elapsed;
                end
                else
                begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                result_total++;
                if (results_due.size() == 0)
                begin
                    if (mismatches < MAX_REPORTS)
                    begin
                        $error("result transaction with no command outstanding");
                    end
                    mismatches++;
                end
                else
                begin
                    due_now = results_due.pop_front();
                    check_field("running_task", 64'(due_now.task_id),
                                64'(res_ch.running_task));
                    check_field("running_vruntime", 64'(due_now.vruntime),
                                64'(res_ch.running_vruntime));
                    check_field("queued_count", 64'(due_now.waiting),
                                64'(res_ch.queued_count));
                    check_field("finished", 64'(due_now.done), 64'(res_ch.finished));
                    check_field("status", 64'(due_now.status), 64'(res_ch.status));
                end
            end
            res_ch.ready <= !((flow == FLOW_RECV_STALLS && $urandom_range(99) < 74) ||
                              (flow == FLOW_BOTH && $urandom_range(99) < 6));
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("tb_fair_share_vruntime_scheduler_unit NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.command    = '0;
        cmd_ch.nice_level = '0;
        cmd_ch.elapsed    = '0;
        res_ch.ready      = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        set_slice_limit(16'hFFFF);

        // nothing running yet, then one nice-2 task alone on the CPU
        queue_cmd(CMD_TICK, 3'b000, 24'hFF_FFFF);
        queue_cmd(CMD_START, 3'b000, 24'h00_0000);
        queue_cmd(CMD_NOP, 3'b111, 24'hFF_FFFF);
        queue_cmd(CMD_ADD, 3'b010, 24'h00_0000);
        queue_cmd(CMD_START, 3'b000, 24'h00_0000);
        queue_cmd(CMD_START, 3'b000, 24'h00_0000);
        queue_cmd(CMD_TICK, 3'b000, 24'h00_0000);
        // charge the lone task the largest elapsed time
        repeat (10) queue_cmd(CMD_TICK, 3'b000, 24'hFF_FFFF);
        // the other raw nice encodings, then fill the run queue past its capacity
        queue_cmd(CMD_ADD, 3'b100, 24'h00_0000);
        queue_cmd(CMD_ADD, 3'b101, 24'h00_0000);
        queue_cmd(CMD_ADD, 3'b011, 24'h00_0000);
        queue_cmd(CMD_ADD, 3'b110, 24'h00_0000);
        queue_cmd(CMD_ADD, 3'b111, 24'h00_0000);
        queue_cmd(CMD_ADD, 3'b000, 24'h00_0000);
        queue_cmd(CMD_ADD, 3'b001, 24'h00_0000);
        queue_cmd(CMD_TICK, 3'b000, 24'h00_0000);
        queue_cmd(CMD_TICK, 3'b000, 24'hFF_FFFF);
        queue_cmd(CMD_TICK, 3'b000, 24'h00_0001);
        repeat (10) queue_cmd(CMD_ADD, 3'b000, 24'h00_0000);
        queue_cmd(CMD_TICK, 3'b000, 24'h00_0000);
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            if (p == 4)
            begin
                set_slice_limit(slices + 16'd3000);
            end
            flow = flow_t'(p % 4);
            queue_random(200);
            wait_drained();
        end

        // next tick finishes, the rest is ignored
        set_slice_limit(16'd1);
        flow = FLOW_RECV_STALLS;
        queue_random(150);
        wait_drained();

        set_slice_limit(16'd0);
        flow = FLOW_FREE;
        queue_random(20);
        wait_drained();

        repeat (30) @(posedge clk);
        if (mismatches == 0 && results_due.size() == 0)
        begin
            $display("tb_fair_share_vruntime_scheduler_unit OK");
        end
        else
        begin
            $display("tb_fair_share_vruntime_scheduler_unit NOT OK");
        end
        $finish;
    end

endmodule

// ----- fair_share_vruntime_scheduler_unit.f -----
src/fsvs_pkg.sv
src/fsvs_if.sv
src/fsvs_ram.sv
src/fsvs_ctrl.sv
src/fsvs_dp.sv
src/fair_share_vruntime_scheduler_unit.sv
test/tb_fair_share_vruntime_scheduler_unit.sv
